### sv/pfce_pkg.sv
`timescale 1ns / 1ps
package pfce_pkg;

  localparam int unsigned CELLS = 25;
  localparam int unsigned LETTERS = 26;
  localparam int unsigned IN_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned MAX_RES = 4;

  localparam logic [4:0] LET_X = 5'd23;
  localparam logic [4:0] LET_Q = 5'd16;
  localparam logic [4:0] LET_J = 5'd9;
  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_LAST = 5'd25;
  localparam logic [6:0] ASCII_A = 7'd97;
  localparam logic [5:0] NONE6 = 6'd63;
  localparam logic [5:0] TAKEN6 = 6'd62;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_KEND = 2'd1,
    OP_TEXT = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // decoded item passed from the front to the back
  typedef struct packed {
    op_t        op;
    logic       is_letter;
    logic [4:0] idx;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
    logic       status;
  } res_t;

  function automatic logic [2:0] cell_row(input logic [4:0] c);
    logic [2:0] r;
    if (c >= 5'd20) r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] c);
    logic [4:0] r5;
    logic [4:0] d;
    r5 = {2'b00, cell_row(c)};
    d = c - ((r5 << 2) + r5);
    return d[2:0];
  endfunction

  // one place forward (encrypt) or back (decrypt), wrapping at the side
  function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
    logic [2:0] r;
    if (back) r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] r5;
    r5 = {2'b00, r};
    return (r5 << 2) + r5 + {2'b00, c};
  endfunction

endpackage

### sv/playfair_cipher_engine_unit.sv
`timescale 1ns / 1ps
// Playfair engine. A text letter that completes a pair is looked up in the cell
// memory, then the square memory, and its results go to the result queue; a key
// end fills the rest of the square (the fill walks the alphabet one letter a cycle).
// The back-end sequencer takes a new item only from idle, so it is through with one
// item before it takes the next; it emits at most one result a cycle.
// Synchronous active-high reset empties both queues, clears the square, sets encrypt.
module playfair_cipher_engine_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] letter_byte,
  input  logic       text_last,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_letter,
  output logic       out_last,
  output logic       status,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import pfce_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_take;
  logic  room;
  logic  res_we;
  res_t  res;
  res_t  head;

  // front: fold case, fold j to i, flag non-letters, and hold a short queue
  pfce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .operation  (operation),
    .letter_byte(letter_byte),
    .text_last  (text_last),
    .full       (full),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take)
  );

  // back: build the square, pair letters, substitute, drop padding x
  pfce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .room     (room),
    .res_we   (res_we),
    .res      (res)
  );

  // result queue: the back only takes an item while at least four slots are free
  pfce_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr_en (res_we),
    .wr_res(res),
    .room  (room),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign out_letter = head.letter;
  assign out_last = head.last;
  assign status = head.status;

endmodule

### sv/pfce_front.sv
`timescale 1ns / 1ps
module pfce_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    operation,
  input  logic [7:0]    letter_byte,
  input  logic          text_last,
  output logic          full,
  output logic          q_valid,
  output pfce_pkg::item_t q_item,
  input  logic          q_take
);
  import pfce_pkg::*;

  item_t      mem [IN_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      dec;
  logic       wr_en;
  logic       rd_en;

  // classify: fold case, fold j onto i, flag non-letters
  always_comb begin
    dec.op = op_t'(operation);
    dec.last = text_last;
    dec.is_letter = 1'b1;
    dec.idx = '0;
    if (letter_byte >= 8'd65 && letter_byte <= 8'd90) begin
      dec.idx = 5'(letter_byte - 8'd65);
    end else if (letter_byte >= 8'd97 && letter_byte <= 8'd122) begin
      dec.idx = 5'(letter_byte - 8'd97);
    end else begin
      dec.is_letter = 1'b0;
    end
    if (dec.idx == LET_J) dec.idx = LET_I;
  end

  assign full = (count == 2'(IN_DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rd_ptr];
  assign wr_en = push && !full;
  assign rd_en = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

### sv/pfce_outq.sv
`timescale 1ns / 1ps
module pfce_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pfce_pkg::res_t wr_res,
  output logic           room,
  input  logic           pop,
  output logic           empty,
  output pfce_pkg::res_t head
);
  import pfce_pkg::*;

  res_t       mem [OUT_DEPTH];
  logic [2:0] wr_ptr;
  logic [2:0] rd_ptr;
  logic [3:0] count;
  logic       rd_en;

  assign empty = (count == 4'd0);
  assign room = (count <= 4'(OUT_DEPTH - MAX_RES));
  assign head = mem[rd_ptr];
  assign rd_en = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 3'd1;
      if (rd_en) rd_ptr <= rd_ptr + 3'd1;
      count <= count + 4'(wr_en) - 4'(rd_en);
    end
  end

endmodule

### sv/pfce_back.sv
`timescale 1ns / 1ps
module pfce_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            q_valid,
  input  pfce_pkg::item_t q_item,
  output logic            q_take,
  input  logic            room,
  output logic            res_we,
  output pfce_pkg::res_t  res
);
  import pfce_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FILL = 9'b000000010,
    S_RDC  = 9'b000000100,
    S_RDS  = 9'b000001000,
    S_EMX  = 9'b000010000,
    S_EMY  = 9'b000100000,
    S_FLSH = 9'b001000000,
    S_STAT = 9'b010000000,
    S_END  = 9'b100000000
  } state_t;

  state_t      state, state_next;
  logic        mode;
  logic [25:0] used, used_next;
  logic [4:0]  fill, fill_next;
  logic [5:0]  pend, pend_next;
  logic [5:0]  lb0, lb0_next;
  logic [5:0]  lb1, lb1_next;
  logic [4:0]  k;
  logic        it_last, it_text;
  logic [4:0]  pa, pb, l2;
  logic        has2, do_flush, do_stat;
  logic [4:0]  pa_next, pb_next, l2_next;
  logic        has2_next, flush_next, stat_next;

  logic [4:0]  ks_mem [CELLS];
  logic [CELLS-1:0] ks_vld;
  logic [4:0]  lc_mem [LETTERS];
  logic [LETTERS-1:0] lc_vld;
  logic [4:0]  lc_qa, lc_qb, ks_qa, ks_qb;

  logic        we;
  logic [4:0]  waddr, widx;
  logic [4:0]  eff_b, ksa, ksb;
  logic        emit;
  res_t        emit_res;
  logic        st_valid;
  res_t        st_res;
  logic        p_none;

  assign p_none = (pend == NONE6);
  assign q_take = (state == S_IDLE) && q_valid && room;
  assign eff_b = (!mode && pa == LET_X && pb == LET_X) ? LET_Q : pb;

  // substitution addresses from the two registered cell numbers
  always_comb begin
    logic [4:0] ca, cb;
    logic [2:0] r1, c1, r2, c2;
    ca = (lc_qa >= 5'(CELLS)) ? 5'd0 : lc_qa;
    cb = (lc_qb >= 5'(CELLS)) ? 5'd0 : lc_qb;
    r1 = cell_row(ca);
    c1 = cell_col(ca);
    r2 = cell_row(cb);
    c2 = cell_col(cb);
    if (r1 == r2) begin
      ksa = cell_addr(r1, step5(c1, mode));
      ksb = cell_addr(r2, step5(c2, mode));
    end else if (c1 == c2) begin
      ksa = cell_addr(step5(r1, mode), c1);
      ksb = cell_addr(step5(r2, mode), c2);
    end else begin
      ksa = cell_addr(r1, c2);
      ksb = cell_addr(r2, c1);
    end
  end

  always_comb begin
    logic [4:0] fv;
    logic [4:0] fill_eff;
    logic [25:0] used_eff;
    state_next = state;
    used_next = used;
    fill_next = fill;
    pend_next = pend;
    lb0_next = lb0;
    lb1_next = lb1;
    pa_next = pa;
    pb_next = pb;
    l2_next = l2;
    has2_next = has2;
    flush_next = do_flush;
    stat_next = do_stat;
    we = 1'b0;
    waddr = fill;
    widx = k;
    emit = 1'b0;
    emit_res = '0;
    fv = (state == S_EMX) ? ks_qa : ks_qb;
    fill_eff = fill;
    used_eff = used;
    case (state)
      S_IDLE: begin
        if (q_take) begin
          has2_next = 1'b0;
          flush_next = 1'b0;
          stat_next = 1'b0;
          case (q_item.op)
            OP_KEY: begin
              if (!q_item.is_letter) begin
                state_next = S_STAT;
              end else begin
                if (fill >= 5'(CELLS)) begin
                  fill_eff = '0;
                  used_eff = '0;
                  pend_next = NONE6;
                  lb0_next = NONE6;
                  lb1_next = NONE6;
                end
                used_next = used_eff;
                fill_next = fill_eff;
                if (!used_eff[q_item.idx]) begin
                  we = 1'b1;
                  waddr = fill_eff;
                  widx = q_item.idx;
                  used_next[q_item.idx] = 1'b1;
                  fill_next = fill_eff + 5'd1;
                end
              end
            end
            OP_KEND: state_next = S_FILL;
            OP_TEXT: begin
              logic npair;
              npair = 1'b0;
              if (q_item.is_letter) begin
                if (p_none) begin
                  if (q_item.last) begin
                    npair = 1'b1;
                    pa_next = q_item.idx;
                    pb_next = LET_X;
                  end else begin
                    pend_next = {1'b0, q_item.idx};
                  end
                end else if (!mode && pend[4:0] == q_item.idx) begin
                  npair = 1'b1;
                  pa_next = pend[4:0];
                  pb_next = LET_X;
                  if (q_item.last) begin
                    has2_next = 1'b1;
                    l2_next = q_item.idx;
                    pend_next = NONE6;
                  end
                end else begin
                  npair = 1'b1;
                  pa_next = pend[4:0];
                  pb_next = q_item.idx;
                  pend_next = NONE6;
                end
                flush_next = mode && q_item.last;
              end else begin
                stat_next = 1'b1;
                if (q_item.last) begin
                  if (!p_none) begin
                    npair = 1'b1;
                    pa_next = pend[4:0];
                    pb_next = LET_X;
                  end
                  flush_next = mode;
                  pend_next = NONE6;
                end
              end
              if (npair) state_next = S_RDC;
              else if (flush_next) state_next = S_FLSH;
              else if (stat_next) state_next = S_STAT;
              else state_next = S_END;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        if (k != LET_J && !used[k] && fill < 5'(CELLS)) begin
          we = 1'b1;
          waddr = fill;
          widx = k;
          used_next[k] = 1'b1;
          fill_next = fill + 5'd1;
        end
        if (k == LET_LAST) state_next = S_IDLE;
      end
      S_RDC: state_next = S_RDS;
      S_RDS: state_next = S_EMX;
      S_EMX, S_EMY: begin
        if (!mode) begin
          emit = 1'b1;
          emit_res.letter = ASCII_A + 7'(fv);
        end else begin
          // hold the newest plain letter back so an x between equals can drop
          if (lb1 != NONE6) begin
            if (lb1[4:0] == LET_X && lb1[5] == 1'b0 && lb0[5] == 1'b0
                && lb0[4:0] == fv) begin
              lb0_next = TAKEN6;
            end else begin
              emit = 1'b1;
              emit_res.letter = ASCII_A + 7'(lb1[4:0]);
              lb0_next = lb1;
            end
          end
          lb1_next = {1'b0, fv};
        end
        if (state == S_EMX) begin
          state_next = S_EMY;
        end else if (has2) begin
          has2_next = 1'b0;
          pa_next = l2;
          pb_next = LET_X;
          state_next = S_RDC;
        end else if (do_flush) begin
          state_next = S_FLSH;
        end else if (do_stat) begin
          state_next = S_STAT;
        end else begin
          state_next = S_END;
        end
      end
      S_FLSH: begin
        if (lb1 != NONE6 && !(lb1 == {1'b0, LET_X} && lb0 != TAKEN6)) begin
          emit = 1'b1;
          emit_res.letter = ASCII_A + 7'(lb1[4:0]);
        end
        lb0_next = NONE6;
        lb1_next = NONE6;
        state_next = do_stat ? S_STAT : S_END;
      end
      S_STAT: begin
        emit = 1'b1;
        emit_res.status = 1'b1;
        state_next = S_END;
      end
      S_END: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // the staged result goes out once the next one arrives or the item ends
  always_comb begin
    res = st_res;
    res_we = 1'b0;
    if (state == S_END) begin
      res_we = st_valid;
      res.last = it_last && it_text;
    end else if (emit) begin
      res_we = st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDC) begin
      lc_qa <= lc_vld[pa] ? lc_mem[pa] : 5'd0;
      lc_qb <= lc_vld[eff_b] ? lc_mem[eff_b] : 5'd0;
    end
    if (state == S_RDS) begin
      ks_qa <= ks_vld[ksa] ? ks_mem[ksa] : 5'd0;
      ks_qb <= ks_vld[ksb] ? ks_mem[ksb] : 5'd0;
    end
    if (we) begin
      ks_mem[waddr] <= widx;
      lc_mem[widx] <= waddr;
    end
    if (emit) st_res <= emit_res;
    pa <= pa_next;
    pb <= pb_next;
    l2 <= l2_next;
    if (q_take) begin
      it_last <= q_item.last;
      it_text <= (q_item.op == OP_TEXT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= 1'b0;
      used <= '0;
      fill <= '0;
      pend <= NONE6;
      lb0 <= NONE6;
      lb1 <= NONE6;
      k <= '0;
      has2 <= 1'b0;
      do_flush <= 1'b0;
      do_stat <= 1'b0;
      ks_vld <= '0;
      lc_vld <= '0;
      st_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      fill <= fill_next;
      has2 <= has2_next;
      do_flush <= flush_next;
      do_stat <= stat_next;
      if (cfg_we) begin
        mode <= cfg_wdata;
        pend <= NONE6;
        lb0 <= NONE6;
        lb1 <= NONE6;
      end else begin
        pend <= pend_next;
        lb0 <= lb0_next;
        lb1 <= lb1_next;
      end
      if (state == S_FILL) k <= k + 5'd1;
      else k <= '0;
      if (we) begin
        ks_vld[waddr] <= 1'b1;
        lc_vld[widx] <= 1'b1;
      end
      if (state == S_END) st_valid <= 1'b0;
      else if (emit) st_valid <= 1'b1;
    end
  end

endmodule

### bench/playfair_cipher_engine_unit_tb.sv
`timescale 1ns / 1ps
module playfair_cipher_engine_unit_tb;
  import pfce_pkg::*;

  localparam logic [4:0] IDX_X = 5'd23;
  localparam logic [4:0] IDX_Q = 5'd16;
  localparam logic [4:0] IDX_J = 5'd9;
  localparam logic [4:0] IDX_I = 5'd8;
  localparam logic [5:0] NO_LETTER = 6'd63;
  localparam logic [5:0] CONSUMED = 6'd62;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       last;
  } stim_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
    logic       status;
  } plain_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [1:0] operation = 2'd0;
  logic [7:0] letter_byte = 8'd0;
  logic text_last = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic full, empty, out_last, status;
  logic [6:0] out_letter;

  playfair_cipher_engine_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .letter_byte(letter_byte), .text_last(text_last), .empty(empty), .pop(pop),
    .out_letter(out_letter), .out_last(out_last), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: square, cell of each letter, pairing and look-back
  logic [4:0]  sq [25];
  logic [4:0]  cell_of [26];
  logic [25:0] used;
  int          filled;
  logic [5:0]  pend;
  logic [5:0]  prev_plain, held_plain;
  logic        decrypt;

  plain_res_t  cipher_results_q[$];
  stim_t       pending_items_q[$];
  plain_res_t  step_res[$];

  int errors = 0;
  int mismatches = 0;
  bit quiet_phase = 0;
  bit hold_off_req = 0;
  int idle_cycles = 0;

  function automatic void put_res(logic [6:0] l, logic st);
    plain_res_t r;
    if (step_res.size() >= 4) return;
    r.letter = l; r.last = 1'b0; r.status = st;
    step_res.push_back(r);
  endfunction

  function automatic void put_idx(logic [4:0] i);
    put_res(7'd97 + {2'b00, i}, 1'b0);
  endfunction

  function automatic void place_letter(logic [4:0] i);
    if (filled >= 25 || i > 25) return;
    sq[filled] = i;
    cell_of[i] = filled[4:0];
    used[i] = 1'b1;
    filled++;
  endfunction

  function automatic void clear_text();
    pend = NO_LETTER; prev_plain = NO_LETTER; held_plain = NO_LETTER;
  endfunction

  function automatic void lookup_pair(input logic [4:0] a, input logic [4:0] b,
                                      input int shift, output logic [4:0] ra,
                                      output logic [4:0] rb);
    int ca, cb, r1, c1, r2, c2;
    ca = int'(cell_of[a]); cb = int'(cell_of[b]);
    if (ca >= 25) ca = 0;
    if (cb >= 25) cb = 0;
    r1 = ca / 5; c1 = ca % 5; r2 = cb / 5; c2 = cb % 5;
    if (r1 == r2) begin
      ra = sq[r1 * 5 + (c1 + shift) % 5];
      rb = sq[r2 * 5 + (c2 + shift) % 5];
    end else if (c1 == c2) begin
      ra = sq[((r1 + shift) % 5) * 5 + c1];
      rb = sq[((r2 + shift) % 5) * 5 + c2];
    end else begin
      ra = sq[r1 * 5 + c2];
      rb = sq[r2 * 5 + c1];
    end
  endfunction

  function automatic void encipher_pair(logic [4:0] a, logic [4:0] b);
    logic [4:0] x, y;
    if (a == IDX_X && b == IDX_X) b = IDX_Q;
    lookup_pair(a, b, 1, x, y);
    put_idx(x); put_idx(y);
  endfunction

  // Hold one plain letter back so that an x between equal letters can be dropped
  function automatic void push_plain(logic [4:0] c);
    if (held_plain != NO_LETTER) begin
      if (held_plain == {1'b0, IDX_X} && prev_plain < 26 && prev_plain == {1'b0, c})
        prev_plain = CONSUMED;
      else begin
        put_idx(held_plain[4:0]);
        prev_plain = held_plain;
      end
    end
    held_plain = {1'b0, c};
  endfunction

  function automatic void flush_plain();
    if (held_plain != NO_LETTER &&
        !(held_plain == {1'b0, IDX_X} && prev_plain != CONSUMED))
      put_idx(held_plain[4:0]);
    prev_plain = NO_LETTER; held_plain = NO_LETTER;
  endfunction

  function automatic void decipher_pair(logic [4:0] a, logic [4:0] b);
    logic [4:0] x, y;
    lookup_pair(a, b, 4, x, y);
    push_plain(x); push_plain(y);
  endfunction

  function automatic void text_letter(logic [4:0] l, logic last);
    if (!decrypt) begin
      if (pend == NO_LETTER) begin
        if (last) encipher_pair(l, IDX_X);
        else pend = {1'b0, l};
      end else if (pend == {1'b0, l}) begin
        encipher_pair(l, IDX_X);
        if (last) begin
          encipher_pair(l, IDX_X);
          pend = NO_LETTER;
        end else pend = {1'b0, l};
      end else begin
        encipher_pair(pend[4:0], l);
        pend = NO_LETTER;
      end
    end else begin
      if (pend == NO_LETTER) begin
        if (last) decipher_pair(l, IDX_X);
        else pend = {1'b0, l};
      end else begin
        decipher_pair(pend[4:0], l);
        pend = NO_LETTER;
      end
      if (last) flush_plain();
    end
  endfunction

  function automatic void text_flush();
    if (!decrypt) begin
      if (pend != NO_LETTER) encipher_pair(pend[4:0], IDX_X);
    end else begin
      if (pend != NO_LETTER) decipher_pair(pend[4:0], IDX_X);
      flush_plain();
    end
    pend = NO_LETTER;
  endfunction

  // Work out the results of one accepted transaction and queue them
  function automatic void predict_cipher(stim_t s);
    logic       is_let;
    logic [4:0] idx;
    plain_res_t r;
    step_res.delete();
    is_let = 1'b1;
    idx = 5'd0;
    if (s.ch >= 8'd65 && s.ch <= 8'd90) idx = 5'(s.ch - 8'd65);
    else if (s.ch >= 8'd97 && s.ch <= 8'd122) idx = 5'(s.ch - 8'd97);
    else is_let = 1'b0;
    if (idx == IDX_J) idx = IDX_I;
    case (s.op)
      OP_KEY: begin
        if (!is_let) put_res(7'd0, 1'b1);
        else begin
          if (filled >= 25) begin
            used = '0; filled = 0; clear_text();
          end
          if (!used[idx]) place_letter(idx);
        end
      end
      OP_KEND: begin
        for (int k = 0; k < 26; k++)
          if (k != IDX_J && !used[k]) place_letter(5'(k));
      end
      OP_TEXT: begin
        if (is_let) text_letter(idx, s.last);
        else begin
          if (s.last) text_flush();
          put_res(7'd0, 1'b1);
        end
        if (s.last && step_res.size() > 0) begin
          r = step_res.pop_back();
          r.last = 1'b1;
          step_res.push_back(r);
        end
      end
      default: ;
    endcase
    foreach (step_res[i]) cipher_results_q.push_back(step_res[i]);
  endfunction

  // Driver: offer the queue head, hold it until accepted, idle in bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_cipher(pending_items_q.pop_front());
      end
      if ((!push || !full) && send_gap > 0) begin
        push <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!push || !full) begin
        if (pending_items_q.size() > 0 && !(push && !full && pending_items_q.size() == 0)
            && (quiet_phase || $urandom_range(0, 7) != 0)) begin
          push <= 1'b1;
          operation <= pending_items_q[0].op;
          letter_byte <= pending_items_q[0].ch;
          text_last <= pending_items_q[0].last;
        end else begin
          push <= 1'b0;
          if (!quiet_phase && pending_items_q.size() > 0)
            send_gap <= $urandom_range(1, 10);
        end
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation
  int recv_gap = 0;
  int hold_count = 0;
  plain_res_t exp_r;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        idle_cycles <= 0;
        if (cipher_results_q.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("unexpected result letter=%0d last=%0d status=%0d",
                     out_letter, out_last, status);
          mismatches++;
        end else begin
          exp_r = cipher_results_q.pop_front();
          if (exp_r.letter !== out_letter || exp_r.last !== out_last ||
              exp_r.status !== status) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch exp letter=%0d last=%0d status=%0d got %0d %0d %0d",
                       exp_r.letter, exp_r.last, exp_r.status,
                       out_letter, out_last, status);
            mismatches++;
          end
        end
      end else if (push && !full) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;

      if (hold_off_req && hold_count == 0) hold_count <= 200;
      if (hold_count > 0) begin
        pop <= 1'b0;
        if (hold_count == 1) hold_off_req <= 1'b0;
        hold_count <= hold_count - 1;
      end else if (recv_gap > 0) begin
        pop <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (quiet_phase || $urandom_range(0, 7) != 0) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        recv_gap <= $urandom_range(1, 10);
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = 8'(97 + $urandom_range(0, 25));
    if ($urandom_range(0, 1)) c = c - 8'd32;
    return c;
  endfunction

  function automatic void add_item(op_t op, logic [7:0] ch, logic last);
    stim_t s;
    s.op = op; s.ch = ch; s.last = last;
    pending_items_q.push_back(s);
  endfunction

  task automatic wait_idle();
    while (pending_items_q.size() > 0 || push || cipher_results_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    decrypt = m;
    clear_text();
  endtask

  // Random key then a text of the given length, mostly letters with doubles and x
  task automatic add_message(int len);
    logic [7:0] c;
    int klen;
    klen = $urandom_range(0, 8);
    for (int k = 0; k < klen; k++)
      add_item(OP_KEY, any_letter(), 1'($urandom_range(0, 1)));
    add_item(OP_KEND, 8'($urandom), 1'($urandom_range(0, 1)));
    c = any_letter();
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0: c = 8'd120;
        1: ;
        2: c = 8'($urandom);
        default: c = any_letter();
      endcase
      add_item(OP_TEXT, c, k == len - 1);
    end
  endtask

  initial begin
    int sent;
    used = '0; filled = 0; decrypt = 1'b0;
    foreach (sq[i]) sq[i] = '0;
    foreach (cell_of[i]) cell_of[i] = '0;
    clear_text();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: text before any key, odd tail, doubles, x-x, non-letters, nop
    add_item(OP_TEXT, 8'd65, 1'b1);
    add_item(OP_KEY, 8'd80, 1'b0);
    add_item(OP_KEY, 8'd108, 1'b0);
    add_item(OP_KEY, 8'd74, 1'b0);
    add_item(OP_KEY, 8'd33, 1'b1);
    add_item(OP_KEND, 8'd0, 1'b0);
    add_item(OP_KEND, 8'd255, 1'b1);
    add_item(OP_TEXT, 8'd108, 1'b0);
    add_item(OP_TEXT, 8'd108, 1'b0);
    add_item(OP_TEXT, 8'd120, 1'b0);
    add_item(OP_TEXT, 8'd88, 1'b0);
    add_item(OP_TEXT, 8'd106, 1'b0);
    add_item(OP_TEXT, 8'd122, 1'b0);
    add_item(OP_TEXT, 8'd90, 1'b1);
    add_item(OP_NOP, 8'd97, 1'b1);
    add_item(OP_TEXT, 8'd120, 1'b1);
    add_item(OP_TEXT, 8'd64, 1'b0);
    add_item(OP_TEXT, 8'd97, 1'b0);
    add_item(OP_TEXT, 8'd91, 1'b1);
    add_item(OP_KEY, 8'd113, 1'b0);
    add_item(OP_KEND, 8'd7, 1'b0);
    set_mode(1'b1);
    // Decrypt: x between equal letters, lone tail, final x
    add_item(OP_TEXT, 8'd97, 1'b0);
    add_item(OP_TEXT, 8'd120, 1'b0);
    add_item(OP_TEXT, 8'd97, 1'b1);
    add_item(OP_TEXT, 8'd98, 1'b1);
    add_item(OP_TEXT, 8'd0, 1'b1);
    sent = 27;

    // Random: modes chosen at random, long receiver hold-offs while sent is in a window
    while (sent < 420) begin
      set_mode(1'($urandom_range(0, 1)));
      // the window is wider than one pass of the loop, so it is always hit
      if (sent > 150 && sent < 210) hold_off_req = 1'b1;
      for (int m = 0; m < 3; m++) begin
        int n;
        n = $urandom_range(1, 14);
        add_message(n);
        sent += n + 5;
      end
      if ($urandom_range(0, 3) == 0) add_item(op_t'($urandom_range(0, 3)),
                                              8'($urandom), 1'($urandom_range(0, 1)));
    end
    set_mode(1'b0);
    quiet_phase = 1'b1;
    add_message(20);
    set_mode(1'b1);
    add_message(20);
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### sim.f
sv/pfce_pkg.sv
sv/pfce_front.sv
sv/pfce_outq.sv
sv/pfce_back.sv
sv/playfair_cipher_engine_unit.sv
bench/playfair_cipher_engine_unit_tb.sv
